// ===== rtl/core/serial_command_pwm_control_core_defines.svh =====
// Assertion macros shared by the serial command PWM control core.
`ifndef SERIAL_COMMAND_PWM_CONTROL_CORE_DEFINES_SVH
`define SERIAL_COMMAND_PWM_CONTROL_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while in reset.
`define SCPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SCPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SCPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/scpc_pkg.sv =====
// Types, constants and helpers for the serial command PWM control core.
package scpc_pkg;

    localparam int MAX_TEXT   = 32;
    localparam int TEXT_LEN_W = $clog2(MAX_TEXT);

    localparam int DUTY_W    = 7;
    localparam int CMP_W     = 10;
    localparam int CODE_W    = 3;

    localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
    localparam logic [DUTY_W-1:0] PWM_SAT    = 7'd101;
    localparam logic [CMP_W-1:0]  CMP_SCALE  = 10'd10;

    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    // bit positions in word_match
    localparam int WM_ON     = 0;
    localparam int WM_OFF    = 1;
    localparam int WM_STATUS = 2;
    localparam logic [2:0] WM_ALL = 3'b111;

    typedef enum logic [CODE_W-1:0] {
        REPLY_ON     = 3'd0,
        REPLY_OFF    = 3'd1,
        REPLY_STATUS = 3'd2,
        REPLY_DUTY   = 3'd3,
        REPLY_ERROR  = 3'd4
    } reply_code_t;

    typedef enum logic [1:0] {
        TAIL_DIGITS  = 2'd0,
        TAIL_PERCENT = 2'd1,
        TAIL_GARBAGE = 2'd2
    } tail_t;

    typedef struct packed {
        reply_code_t        code;
        logic               led_on;
        logic [DUTY_W-1:0]  duty_percent;
        logic [CMP_W-1:0]   compare_value;
    } reply_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/scpc_byte_if.sv =====
// Received-byte channel: valid/ready with one byte of payload.
interface scpc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/scpc_reply_if.sv =====
// Reply channel: valid/ready with reply code, LED state, duty and compare value.
interface scpc_reply_if;
    logic                            valid;
    logic                            ready;
    logic [scpc_pkg::CODE_W-1:0]     reply_code;
    logic                            led_on;
    logic [scpc_pkg::DUTY_W-1:0]     duty_percent;
    logic [scpc_pkg::CMP_W-1:0]      compare_value;

    modport source (output valid, output reply_code, output led_on,
                    output duty_percent, output compare_value, input ready);
    modport sink   (input valid, input reply_code, input led_on,
                    input duty_percent, input compare_value, output ready);
endinterface

// ===== rtl/core/scpc_parser.sv =====
// Per-byte command matcher, LED/duty state and reply generation.
`include "serial_command_pwm_control_core_defines.svh"

module scpc_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output scpc_pkg::reply_t      res
);

    localparam int LW = scpc_pkg::TEXT_LEN_W;
    localparam logic [LW-1:0] LEN_LAST = LW'(scpc_pkg::MAX_TEXT - 1);

    logic [LW-1:0]                  text_len_reg, text_len_next;
    logic [2:0]                     word_match_reg, word_match_next;
    logic                           prefix_ok_reg, prefix_ok_next;
    logic [scpc_pkg::DUTY_W-1:0]    pwm_value_reg, pwm_value_next;
    logic                           digit_seen_reg, digit_seen_next;
    scpc_pkg::tail_t                tail_reg, tail_next;
    logic                           text_ended_reg, text_ended_next;
    logic                           led_en_reg, led_en_next;
    logic [scpc_pkg::DUTY_W-1:0]    duty_reg, duty_next;

    logic [7:0]                     up;
    logic [LW-1:0]                  pos;
    logic [2:0]                     wm_end;
    logic                           pok_end;
    logic [2:0]                     wm_fin;
    logic                           pok_fin;
    logic                           on_hit, off_hit, status_hit, prefix_hit;
    logic                           is_digit;
    logic [scpc_pkg::CMP_W-1:0]     pwm_acc;
    scpc_pkg::reply_code_t          code;

    assign up  = scpc_pkg::upcase(rx_byte);
    assign pos = text_len_reg;
    assign is_digit = (rx_byte >= scpc_pkg::CH_ZERO) && (rx_byte <= scpc_pkg::CH_NINE);

    // candidate words that still fit the byte at this position
    assign on_hit     = (pos == LW'(0) && up == "O") || (pos == LW'(1) && up == "N");
    assign off_hit    = (pos == LW'(0) && up == "O") || (pos == LW'(1) && up == "F")
                     || (pos == LW'(2) && up == "F");
    assign status_hit = (pos == LW'(0) && up == "S") || (pos == LW'(1) && up == "T")
                     || (pos == LW'(2) && up == "A") || (pos == LW'(3) && up == "T")
                     || (pos == LW'(4) && up == "U") || (pos == LW'(5) && up == "S");
    assign prefix_hit = (pos == LW'(0) && up == "P") || (pos == LW'(1) && up == "W")
                     || (pos == LW'(2) && up == "M")
                     || (pos == LW'(3) && rx_byte == scpc_pkg::CH_COLON);

    // text ending at the current length: only full-length words survive
    assign wm_end  = word_match_reg & {pos == LW'(6), pos == LW'(3), pos == LW'(2)};
    assign pok_end = prefix_ok_reg && (pos >= LW'(4));
    assign wm_fin  = text_ended_reg ? word_match_reg : wm_end;
    assign pok_fin = text_ended_reg ? prefix_ok_reg  : pok_end;

    assign pwm_acc = scpc_pkg::CMP_W'(pwm_value_reg) * scpc_pkg::CMP_SCALE
                   + scpc_pkg::CMP_W'(rx_byte[3:0]);

    always_comb
    begin
        text_len_next   = text_len_reg;
        word_match_next = word_match_reg;
        prefix_ok_next  = prefix_ok_reg;
        pwm_value_next  = pwm_value_reg;
        digit_seen_next = digit_seen_reg;
        tail_next       = tail_reg;
        text_ended_next = text_ended_reg;
        led_en_next     = led_en_reg;
        duty_next       = duty_reg;
        code            = scpc_pkg::REPLY_ERROR;
        res_valid       = 1'b0;

        if (fire)
        begin
            if (rx_byte == scpc_pkg::CH_BANG)
            begin
                res_valid = 1'b1;
                priority if (wm_fin[scpc_pkg::WM_ON])
                begin
                    led_en_next = 1'b1;
                    code        = scpc_pkg::REPLY_ON;
                end
                else if (wm_fin[scpc_pkg::WM_OFF])
                begin
                    led_en_next = 1'b0;
                    code        = scpc_pkg::REPLY_OFF;
                end
                else if (wm_fin[scpc_pkg::WM_STATUS])
                begin
                    code = scpc_pkg::REPLY_STATUS;
                end
                else if (pok_fin && digit_seen_reg && tail_reg != scpc_pkg::TAIL_GARBAGE
                         && pwm_value_reg <= scpc_pkg::DUTY_MAX)
                begin
                    duty_next = pwm_value_reg;
                    code      = scpc_pkg::REPLY_DUTY;
                end
                else
                begin
                    code = scpc_pkg::REPLY_ERROR;
                end
                text_len_next   = '0;
                word_match_next = scpc_pkg::WM_ALL;
                prefix_ok_next  = 1'b1;
                pwm_value_next  = '0;
                digit_seen_next = 1'b0;
                tail_next       = scpc_pkg::TAIL_DIGITS;
                text_ended_next = 1'b0;
            end
            else if (rx_byte == scpc_pkg::CH_CR || rx_byte == scpc_pkg::CH_LF)
            begin
                // line endings are dropped
            end
            else if (text_len_reg < LEN_LAST)
            begin
                text_len_next = text_len_reg + LW'(1);
                if (!text_ended_reg)
                begin
                    if (rx_byte == scpc_pkg::CH_NUL)
                    begin
                        word_match_next = wm_end;
                        prefix_ok_next  = pok_end;
                        text_ended_next = 1'b1;
                    end
                    else
                    begin
                        word_match_next = word_match_reg & {status_hit, off_hit, on_hit};
                        if (pos < LW'(4))
                        begin
                            prefix_ok_next = prefix_ok_reg && prefix_hit;
                        end
                        else if (tail_reg == scpc_pkg::TAIL_DIGITS)
                        begin
                            priority if (is_digit)
                            begin
                                pwm_value_next  = (pwm_acc > scpc_pkg::CMP_W'(scpc_pkg::DUTY_MAX))
                                                ? scpc_pkg::PWM_SAT
                                                : pwm_acc[scpc_pkg::DUTY_W-1:0];
                                digit_seen_next = 1'b1;
                            end
                            else if (rx_byte == scpc_pkg::CH_PERCENT)
                            begin
                                tail_next = scpc_pkg::TAIL_PERCENT;
                            end
                            else
                            begin
                                tail_next = scpc_pkg::TAIL_GARBAGE;
                            end
                        end
                        else
                        begin
                            tail_next = scpc_pkg::TAIL_GARBAGE;
                        end
                    end
                end
            end
            else
            begin
                // overflow: drop the byte and start over
                text_len_next   = '0;
                word_match_next = scpc_pkg::WM_ALL;
                prefix_ok_next  = 1'b1;
                pwm_value_next  = '0;
                digit_seen_next = 1'b0;
                tail_next       = scpc_pkg::TAIL_DIGITS;
                text_ended_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res.code          = code;
        res.led_on        = led_en_next;
        res.duty_percent  = duty_next;
        res.compare_value = led_en_next
                          ? scpc_pkg::CMP_W'(duty_next) * scpc_pkg::CMP_SCALE
                          : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_len_reg   <= '0;
            word_match_reg <= scpc_pkg::WM_ALL;
            prefix_ok_reg  <= 1'b1;
            pwm_value_reg  <= '0;
            digit_seen_reg <= 1'b0;
            tail_reg       <= scpc_pkg::TAIL_DIGITS;
            text_ended_reg <= 1'b0;
            led_en_reg     <= 1'b0;
            duty_reg       <= scpc_pkg::DUTY_RESET;
        end
        else
        begin
            text_len_reg   <= text_len_next;
            word_match_reg <= word_match_next;
            prefix_ok_reg  <= prefix_ok_next;
            pwm_value_reg  <= pwm_value_next;
            digit_seen_reg <= digit_seen_next;
            tail_reg       <= tail_next;
            text_ended_reg <= text_ended_next;
            led_en_reg     <= led_en_next;
            duty_reg       <= duty_next;
        end
    end

    `SCPC_ASSERT_IMP(a_duty_range, clk, rst_n, 1'b1,
                     duty_reg <= scpc_pkg::DUTY_MAX, "duty out of range")
    `SCPC_ASSERT_IMP(a_pwm_range, clk, rst_n, 1'b1,
                     pwm_value_reg <= scpc_pkg::PWM_SAT, "pwm value above saturation")
    `SCPC_ASSERT_NXT(a_bang_clears, clk, rst_n, fire && rx_byte == scpc_pkg::CH_BANG,
                     text_len_reg == '0 && word_match_reg == scpc_pkg::WM_ALL
                     && !text_ended_reg, "command end did not clear text")

endmodule

// ===== rtl/core/scpc_outbuf.sv =====
// Two-entry reply buffer so input bytes keep flowing while a reply is stalled.
`include "serial_command_pwm_control_core_defines.svh"

module scpc_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  scpc_pkg::reply_t      wr_data,
    output logic                  can_take,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output scpc_pkg::reply_t      rd_data
);

    scpc_pkg::reply_t   entry_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               rd_fire;

    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign can_take = (count_reg != 2'd2);
    assign rd_fire  = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_en   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_fire ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({wr_en, rd_fire})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `SCPC_ASSERT_IMP(a_no_overflow, clk, rst_n, wr_en, count_reg != 2'd2,
                     "write into full reply buffer")
    `SCPC_ASSERT_IMP(a_count_ptrs, clk, rst_n, count_reg == 2'd1, wr_ptr_reg != rd_ptr_reg,
                     "buffer pointers disagree with count")
    `SCPC_ASSERT_NXT(a_head_stable, clk, rst_n, rd_valid && !rd_ready,
                     rd_valid && $stable(rd_data), "stalled reply changed")

endmodule

// ===== rtl/core/serial_command_pwm_control_core.sv =====
// Top level of the serial command PWM control core.
//
//  channel       dir  payload                                         handshake
//  rx_stream     in   rx_byte[7:0]                                    valid/ready
//  reply_stream  out  reply_code[2:0] led_on duty_percent[6:0]        valid/ready
//                     compare_value[9:0]
//
// One byte is taken per cycle; a '!' byte gives one reply, loaded into a
// two-entry reply buffer on the transfer edge and shown the next cycle if no older reply waits.
// Bytes are refused only while two replies wait in the buffer.
// Reset (rst_n low, asynchronous) clears the text, turns the LED off and sets duty to 50.
module serial_command_pwm_control_core (
    input  logic             clk,
    input  logic             rst_n,
    scpc_byte_if.sink        rx_stream,
    scpc_reply_if.source     reply_stream
);

    logic                 fire;
    logic                 res_valid;
    logic                 can_take;
    scpc_pkg::reply_t     res;
    scpc_pkg::reply_t     head;

    assign rx_stream.ready = can_take;
    assign fire            = rx_stream.valid && can_take;

    scpc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rx_byte   (rx_stream.rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    scpc_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .can_take (can_take),
        .rd_valid (reply_stream.valid),
        .rd_ready (reply_stream.ready),
        .rd_data  (head)
    );

    assign reply_stream.reply_code    = scpc_pkg::CODE_W'(head.code);
    assign reply_stream.led_on        = head.led_on;
    assign reply_stream.duty_percent  = head.duty_percent;
    assign reply_stream.compare_value = head.compare_value;

endmodule
